>>> src/spl_pkg.sv
`default_nettype none

package spl_pkg;

  // Fixed field widths of a beat.
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned PIN_IDX_W = 5;
  localparam int unsigned DUTY_W    = 8;
  localparam int unsigned LEVEL_W   = 7;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned MAX_PINS  = 32;

  // Kind codes on the slave-side tuser.
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_ENABLE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_ENABLE = 1'b1;

  // Level scaling and random draw constants.
  localparam int unsigned LEVEL_SCALE = 100;
  localparam int unsigned LUT_DEPTH   = 256;
  localparam logic [COUNT_W-1:0] RAND_MOD    = 8'd99;
  localparam logic [COUNT_W-1:0] RAND_MOD_X2 = 8'd198;

  // Queue between decode and execute.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [MAX_PINS-1:0]  samples;
    logic                 pin_ok;
    logic [PIN_IDX_W-1:0] pin_idx;
    logic [DUTY_W-1:0]    duty;
  } op_t;

endpackage

`default_nettype wire

>>> src/spl_front.sv
`default_nettype none

module spl_front #(
  parameter int unsigned NUM_PINS = 19
) (
  input  wire logic                           in_valid_i,
  input  wire logic [spl_pkg::KIND_W-1:0]     kind_i,
  input  wire logic [NUM_PINS-1:0]            samples_i,
  input  wire logic [spl_pkg::PIN_IDX_W-1:0]  pin_idx_i,
  input  wire logic [spl_pkg::DUTY_W-1:0]     duty_i,
  output logic                                push_o,
  output spl_pkg::op_t                        op_o
);

  localparam int unsigned IDX_LIMIT_W = spl_pkg::PIN_IDX_W + 1;

  spl_pkg::op_e op_kind;

  always_comb begin
    case (kind_i)
      spl_pkg::KIND_TICK:  op_kind = spl_pkg::OP_TICK;
      spl_pkg::KIND_WRITE: op_kind = spl_pkg::OP_WRITE;
      spl_pkg::KIND_READ:  op_kind = spl_pkg::OP_READ;
      default:             op_kind = spl_pkg::OP_NOP;
    endcase
  end

  assign push_o         = in_valid_i;
  assign op_o.op        = op_kind;
  assign op_o.samples   = spl_pkg::MAX_PINS'(samples_i);
  // Writes and reads to pins that do not exist become no-ops in the back end.
  assign op_o.pin_ok    = (IDX_LIMIT_W'(pin_idx_i) < IDX_LIMIT_W'(NUM_PINS));
  assign op_o.pin_idx   = pin_idx_i;
  assign op_o.duty      = duty_i;

endmodule

`default_nettype wire

>>> src/spl_queue.sv
`default_nettype none

module spl_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire spl_pkg::op_t  data_i,
  output logic               ready_o,
  output logic               valid_o,
  output spl_pkg::op_t       data_o,
  input  wire logic          pop_i
);

  spl_pkg::op_t                         entry_q [spl_pkg::QUEUE_DEPTH];
  logic [spl_pkg::QUEUE_PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [spl_pkg::QUEUE_PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [spl_pkg::QUEUE_CNT_W-1:0]      count_q, count_d;
  logic                                 do_push;

  assign ready_o = (count_q != spl_pkg::QUEUE_CNT_W'(spl_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && ready_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({do_push, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue popped while empty");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not follow a push");
`endif

endmodule

`default_nettype wire

>>> src/spl_back.sv
`default_nettype none

module spl_back #(
  parameter int unsigned NUM_PINS      = 19,
  parameter int unsigned SAMPLE_WINDOW = 200
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  input  wire logic [spl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [NUM_PINS-1:0]               cfg_data_i,
  input  wire logic                              q_valid_i,
  input  wire spl_pkg::op_t                      q_data_i,
  output logic                                   q_pop_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [NUM_PINS-1:0]                    pin_drive_o,
  output logic [NUM_PINS-1:0]                    window_done_o,
  output logic [spl_pkg::LEVEL_W-1:0]            level_o
);

  localparam int unsigned PIN_SEL_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
  localparam logic [spl_pkg::COUNT_W-1:0] WINDOW = spl_pkg::COUNT_W'(SAMPLE_WINDOW);

  typedef logic [spl_pkg::LEVEL_W-1:0] level_lut_t [spl_pkg::LUT_DEPTH];

  // Level for each possible high total at the end of a window.
  function automatic level_lut_t build_level_lut();
    level_lut_t lut;
    for (int h = 0; h < spl_pkg::LUT_DEPTH; h++) begin
      lut[h] = spl_pkg::LEVEL_W'((h * spl_pkg::LEVEL_SCALE) / SAMPLE_WINDOW);
    end
    return lut;
  endfunction

  localparam level_lut_t LEVEL_LUT = build_level_lut();

  logic [NUM_PINS-1:0]                in_en_q, out_en_q;
  logic [spl_pkg::COUNT_W-1:0]        count_q [NUM_PINS];
  logic [spl_pkg::COUNT_W-1:0]        count_d [NUM_PINS];
  logic [spl_pkg::COUNT_W-1:0]        total_q [NUM_PINS];
  logic [spl_pkg::COUNT_W-1:0]        total_d [NUM_PINS];
  logic [spl_pkg::LEVEL_W-1:0]        meas_q  [NUM_PINS];
  logic [spl_pkg::LEVEL_W-1:0]        meas_d  [NUM_PINS];
  logic [spl_pkg::DUTY_W-1:0]         duty_q  [NUM_PINS];
  logic [spl_pkg::DUTY_W-1:0]         duty_d  [NUM_PINS];
  logic [spl_pkg::COUNT_W-1:0]        rnd_q, rnd_d;
  logic [NUM_PINS-1:0]                drive_q, drive_d;
  logic [NUM_PINS-1:0]                done;
  logic [spl_pkg::LEVEL_W-1:0]        level;
  logic [spl_pkg::COUNT_W-1:0]        rev;
  logic [spl_pkg::COUNT_W-1:0]        rev_mod;
  logic [spl_pkg::DUTY_W-1:0]         draw;
  logic [spl_pkg::COUNT_W-1:0]        next_count;
  logic [PIN_SEL_W-1:0]               pin_sel;
  logic [NUM_PINS-1:0]                samples;
  logic                               pop;
  logic                               out_valid_q;
  logic [NUM_PINS-1:0]                pin_drive_q, window_done_q;
  logic [spl_pkg::LEVEL_W-1:0]        level_q;

  assign pop     = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = pop;
  assign pin_sel = q_data_i.pin_idx[PIN_SEL_W-1:0];
  assign samples = q_data_i.samples[NUM_PINS-1:0];

  // Draw in 1..99 from the bit-reversed counter.
  always_comb begin
    for (int i = 0; i < spl_pkg::COUNT_W; i++) begin
      rev[i] = rnd_q[spl_pkg::COUNT_W-1-i];
    end
    if (rev >= spl_pkg::RAND_MOD_X2) begin
      rev_mod = rev - spl_pkg::RAND_MOD_X2;
    end else if (rev >= spl_pkg::RAND_MOD) begin
      rev_mod = rev - spl_pkg::RAND_MOD;
    end else begin
      rev_mod = rev;
    end
    draw = spl_pkg::DUTY_W'(rev_mod) + 1'b1;
  end

  always_comb begin
    count_d    = count_q;
    total_d    = total_q;
    meas_d     = meas_q;
    duty_d     = duty_q;
    rnd_d      = rnd_q;
    drive_d    = drive_q;
    done       = '0;
    level      = '0;
    next_count = '0;
    case (q_data_i.op)
      spl_pkg::OP_TICK: begin
        for (int n = 0; n < NUM_PINS; n++) begin
          if (in_en_q[n]) begin
            next_count = count_q[n] + 1'b1;
            if (next_count >= WINDOW) begin
              meas_d[n]  = LEVEL_LUT[total_q[n]];
              count_d[n] = '0;
              total_d[n] = '0;
              done[n]    = 1'b1;
            end else begin
              count_d[n] = next_count;
              if (samples[n]) begin
                total_d[n] = total_q[n] + 1'b1;
              end
            end
          end
        end
        if (out_en_q != '0) begin
          rnd_d = rnd_q + 1'b1;
          for (int n = 0; n < NUM_PINS; n++) begin
            drive_d[n] = out_en_q[n] && (duty_q[n] >= draw);
          end
        end else begin
          drive_d = '0;
        end
      end
      spl_pkg::OP_WRITE: begin
        if (q_data_i.pin_ok) begin
          duty_d[pin_sel] = q_data_i.duty;
        end
      end
      spl_pkg::OP_READ: begin
        if (q_data_i.pin_ok) begin
          level = meas_q[pin_sel];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_en_q     <= '0;
      out_en_q    <= '0;
      rnd_q       <= '0;
      drive_q     <= '0;
      out_valid_q <= 1'b0;
      for (int n = 0; n < NUM_PINS; n++) begin
        count_q[n] <= '0;
        total_q[n] <= '0;
        meas_q[n]  <= '0;
        duty_q[n]  <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          spl_pkg::CFG_INPUT_ENABLE:  in_en_q  <= cfg_data_i;
          spl_pkg::CFG_OUTPUT_ENABLE: out_en_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (pop) begin
        count_q     <= count_d;
        total_q     <= total_d;
        meas_q      <= meas_d;
        duty_q      <= duty_d;
        rnd_q       <= rnd_d;
        drive_q     <= drive_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      pin_drive_q   <= drive_d;
      window_done_q <= done;
      level_q       <= level;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pin_drive_o   = pin_drive_q;
  assign window_done_o = window_done_q;
  assign level_o       = level_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !pop)
    else $error("result register overwritten while stalled");

  a_rnd_only_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rnd_q != $past(rnd_q)) |-> $past(pop && (q_data_i.op == spl_pkg::OP_TICK) &&
                                      (out_en_q != '0)))
    else $error("random counter moved without a driving tick");

  a_idle_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (q_data_i.op == spl_pkg::OP_TICK) && (out_en_q == '0)) |=> (drive_q == '0))
    else $error("drive not cleared with no output pins enabled");

  a_done_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (q_data_i.op != spl_pkg::OP_TICK)) |=> (window_done_q == '0))
    else $error("window done flagged on a non-tick beat");
`endif

endmodule

`default_nettype wire

>>> src/stochastic_pin_level_codec.sv
// Stochastic pin level codec.
// Slave stream: one beat per item. tuser carries the kind (tick, duty write,
// level read); tdata carries pin samples, pin index and duty value.
// Master stream: exactly one result beat per accepted item, in order, with
// the drive levels, the pins whose sample window closed on this tick, and
// the measured level for a read.
// Config channel: cfg_index_i 0 writes the input enable mask, 1 the output
// enable mask; it is always ready. The user must write it only while the
// block is idle; the block does not enforce this. One item is taken every
// cycle unless the master side stalls: a two-entry queue separates decode
// from execution, and all pins of a tick update in parallel in the execute
// stage. If the master side stalls, the result register holds its beat, the
// queue fills, and tready drops once both queue entries are occupied.
// Reset clears all counters, totals, levels, duty values, the random
// counter, the drive levels and the enable masks; the block is ready at once.
`default_nettype none

module stochastic_pin_level_codec #(
  parameter int unsigned NUM_PINS      = 19,
  parameter int unsigned SAMPLE_WINDOW = 200,
  localparam int unsigned IN_BITS  = NUM_PINS + spl_pkg::PIN_IDX_W + spl_pkg::DUTY_W,
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS = 2 * NUM_PINS + spl_pkg::LEVEL_W,
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // pin_samples, pin_index, duty_value
  input  wire logic [IN_W-1:0]                s_axis_tdata,
  // kind
  input  wire logic [spl_pkg::KIND_W-1:0]     s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // pin_drive, window_done, measured_level
  output logic [OUT_W-1:0]                    m_axis_tdata,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [spl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [NUM_PINS-1:0]            cfg_data_i
);

  localparam int unsigned IDX_LO   = NUM_PINS;
  localparam int unsigned DUTY_LO  = NUM_PINS + spl_pkg::PIN_IDX_W;

  logic                              push;
  spl_pkg::op_t                      front_op;
  logic                              q_valid;
  spl_pkg::op_t                      q_op;
  logic                              q_pop;
  logic [NUM_PINS-1:0]               pin_drive;
  logic [NUM_PINS-1:0]               window_done;
  logic [spl_pkg::LEVEL_W-1:0]       level;

  spl_front #(
    .NUM_PINS (NUM_PINS)
  ) u_front (
    .in_valid_i (s_axis_tvalid),
    .kind_i     (s_axis_tuser),
    .samples_i  (s_axis_tdata[NUM_PINS-1:0]),
    .pin_idx_i  (s_axis_tdata[IDX_LO +: spl_pkg::PIN_IDX_W]),
    .duty_i     (s_axis_tdata[DUTY_LO +: spl_pkg::DUTY_W]),
    .push_o     (push),
    .op_o       (front_op)
  );

  spl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_op),
    .ready_o (s_axis_tready),
    .valid_o (q_valid),
    .data_o  (q_op),
    .pop_i   (q_pop)
  );

  spl_back #(
    .NUM_PINS      (NUM_PINS),
    .SAMPLE_WINDOW (SAMPLE_WINDOW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .q_valid_i     (q_valid),
    .q_data_i      (q_op),
    .q_pop_o       (q_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .pin_drive_o   (pin_drive),
    .window_done_o (window_done),
    .level_o       (level)
  );

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = OUT_W'({level, window_done, pin_drive});

endmodule

`default_nettype wire
